@@ sv/phwbc_pkg.sv @@
// ----------------------------------------------------------------------------
// phwbc_pkg
// Types and constants shared by the per-host window byte counter.
// ----------------------------------------------------------------------------
package phwbc_pkg;

  localparam int SLOTS      = 60;
  localparam int HOSTS      = 256;
  localparam int COUNT_BITS = 32;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int HOST_W  = $clog2(HOSTS);
  localparam int ADDR_W  = HOST_W + SLOT_W;
  localparam int WIN_W   = 38;
  localparam int DAYB_W  = 48;
  localparam int DAYP_W  = 40;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  localparam logic [31:0] MASK_RESET  = 32'hFFFF_0000;
  localparam logic [31:0] VALUE_RESET = 32'hC0A8_0000;
  localparam logic [7:0]  MAC_BCAST   = 8'hFF;
  localparam logic [7:0]  ETH_IPV4_HI = 8'h08;

  localparam logic [COUNT_BITS-1:0] SLOT_MAX = '1;
  localparam logic [WIN_W-1:0]      WIN_MAX  = '1;
  localparam logic [DAYB_W-1:0]     DAYB_MAX = '1;
  localparam logic [DAYP_W-1:0]     DAYP_MAX = '1;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_ROLL  = 2'd3
  } mode_t;

  localparam logic [0:0] REG_MASK  = 1'b0;
  localparam logic [0:0] REG_VALUE = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    mode_t             mode;
    logic              counted;
    logic [HOST_W-1:0] host;
    logic [15:0]       len;
  } cmd_t;

endpackage

@@ sv/phwbc_if.sv @@
// ----------------------------------------------------------------------------
// phwbc_in_if / phwbc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface phwbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  dest_mac_first;
  logic [7:0]  ethertype_high;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] frame_length;
  logic [7:0]  query_host;
  modport source (output valid, mode, dest_mac_first, ethertype_high, source_address,
                  dest_address, frame_length, query_host, input ready);
  modport sink (input valid, mode, dest_mac_first, ethertype_high, source_address,
                dest_address, frame_length, query_host, output ready);
endinterface

interface phwbc_out_if;
  logic        valid;
  logic        ready;
  logic        counted;
  logic [7:0]  host_index;
  logic [37:0] window_bytes;
  logic [47:0] day_bytes;
  logic [39:0] day_packets;
  modport source (output valid, counted, host_index, window_bytes, day_bytes,
                  day_packets, input ready);
  modport sink (input valid, counted, host_index, window_bytes, day_bytes,
                day_packets, output ready);
endinterface

@@ sv/per_host_window_byte_counter.sv @@
// A query reads the host's slot words one per cycle, and a tick clears the new slot
// for one host per cycle.
// Flow: one request in the back end at a time, started once the output register
// is free; a two-entry queue in front keeps accepting while results wait, until full.
// Reset: synchronous active low; afterwards a clearing pass over all HOSTS*SLOTS words
// (15360) zeroes the slot memory before the first request is executed.
// ----------------------------------------------------------------------------
// per_host_window_byte_counter
// Top level: config registers, front classifier and back execution unit.
// ----------------------------------------------------------------------------
module per_host_window_byte_counter
  import phwbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  phwbc_in_if.sink    in_ch,
  phwbc_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] mask_r, value_r;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  assign cfg_pready = 1'b1;

  // register read
  always_comb begin
    case (cfg_paddr[2])
      REG_MASK:  cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? mask_r : '0;
      REG_VALUE: cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? value_r : '0;
      default:   cfg_prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= MASK_RESET;
      value_r <= VALUE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_paddr[2] == REG_MASK) mask_r <= cfg_pwdata;
      else                          value_r <= cfg_pwdata;
    end
  end

  phwbc_front u_front (
    .clk, .rst_n, .in_ch,
    .subnet_mask(mask_r), .subnet_value(value_r),
    .cmd_valid, .cmd, .cmd_pop
  );

  phwbc_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .out_ch
  );

endmodule

@@ sv/phwbc_front.sv @@
// ----------------------------------------------------------------------------
// phwbc_front
// Accepts requests, classifies frames against the subnet and holds a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module phwbc_front
  import phwbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  phwbc_in_if.sink    in_ch,
  input  logic [31:0] subnet_mask,
  input  logic [31:0] subnet_value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       src_loc, dst_loc;
  logic [31:0] loc_addr;
  cmd_t       cls;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_r];

  // frame classification
  always_comb begin
    src_loc  = (in_ch.source_address & subnet_mask) == subnet_value;
    dst_loc  = (in_ch.dest_address & subnet_mask) == subnet_value;
    loc_addr = dst_loc ? in_ch.dest_address : in_ch.source_address;
    cls.mode = mode_t'(in_ch.mode);
    cls.len  = in_ch.frame_length;
    cls.counted = (in_ch.dest_mac_first != MAC_BCAST) && (in_ch.ethertype_high == ETH_IPV4_HI)
                  && (src_loc != dst_loc) && (loc_addr[15:8] == 8'd0);
    cls.host = cls.counted ? loc_addr[HOST_W-1:0] : '0;
    if (cls.mode == MODE_QUERY) cls.host = in_ch.query_host;
    if (cls.mode != MODE_FRAME) cls.counted = 1'b0;
  end

  // queue pointers
  always_comb begin
    rd_nxt  = rd_r ^ cmd_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
  end

endmodule

@@ sv/phwbc_back.sv @@
// ----------------------------------------------------------------------------
// phwbc_back
// Executes commands on the slot memory and daily totals and drives results.
// ----------------------------------------------------------------------------
module phwbc_back
  import phwbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  phwbc_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FRD, S_FWR, S_TICK, S_QRD, S_QSUM, S_OUT
  } state_t;

  logic [COUNT_BITS-1:0] mem [HOSTS*SLOTS];
  logic [COUNT_BITS-1:0] rdata_r;

  state_t              st_r, st_nxt;
  cmd_t                cur_r, cur_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [HOST_W-1:0]   hidx_r, hidx_nxt;
  logic                cdone_r, cdone_nxt;
  logic                rdv_r, rdv_nxt;
  logic [WIN_W-1:0]    sum_r, sum_nxt;
  logic [DAYB_W-1:0]   dayb_r, dayb_nxt;
  logic [DAYP_W-1:0]   dayp_r, dayp_nxt;
  logic                ov_r, ov_nxt;
  logic                oc_r, oc_nxt;
  logic [7:0]          oh_r, oh_nxt;
  logic [WIN_W-1:0]    ow_r, ow_nxt;
  logic [DAYB_W-1:0]   odb_r, odb_nxt;
  logic [DAYP_W-1:0]   odp_r, odp_nxt;

  logic                  we, re;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS:0]   slot_sum;
  logic [WIN_W:0]        win_sum;
  logic [DAYB_W:0]       db_sum;
  logic [SLOT_W-1:0]     slot_inc;

  function automatic logic [ADDR_W-1:0] addr_of(logic [HOST_W-1:0] h, logic [SLOT_W-1:0] s);
    return ADDR_W'(h) * ADDR_W'(SLOTS) + ADDR_W'(s);
  endfunction

  assign out_ch.valid        = ov_r;
  assign out_ch.counted      = oc_r;
  assign out_ch.host_index   = oh_r;
  assign out_ch.window_bytes = ow_r;
  assign out_ch.day_bytes    = odb_r;
  assign out_ch.day_packets  = odp_r;

  assign slot_sum = {1'b0, rdata_r} + {{(COUNT_BITS-16+1){1'b0}}, cur_r.len};
  assign win_sum  = {1'b0, sum_r} + (WIN_W+1)'(rdata_r);
  assign db_sum   = {1'b0, dayb_r} + {{(DAYB_W-16+1){1'b0}}, cur_r.len};
  assign slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  // sequencer
  always_comb begin
    st_nxt = st_r; cur_nxt = cur_r; slot_nxt = slot_r; idx_nxt = idx_r;
    hidx_nxt = hidx_r; cdone_nxt = cdone_r; rdv_nxt = 1'b0; sum_nxt = sum_r;
    dayb_nxt = dayb_r; dayp_nxt = dayp_r;
    ov_nxt = ov_r; oc_nxt = oc_r; oh_nxt = oh_r; ow_nxt = ow_r;
    odb_nxt = odb_r; odp_nxt = odp_r;
    cmd_pop = 1'b0; we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        we = 1'b1; waddr = addr_of(hidx_r, idx_r);
        hidx_nxt = hidx_r + 1'b1;
        if (hidx_r == HOST_W'(HOSTS-1)) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == SLOT_LAST) begin
            idx_nxt = '0;
            st_nxt  = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        // start only once the output register is free
        if (cmd_valid && (!ov_r || out_ch.ready)) begin
          cmd_pop = 1'b1; cur_nxt = cmd;
          oc_nxt = 1'b0; oh_nxt = '0; ow_nxt = '0; odb_nxt = '0; odp_nxt = '0;
          unique case (cmd.mode)
            MODE_FRAME: st_nxt = cmd.counted ? S_FRD : S_OUT;
            MODE_TICK: begin
              slot_nxt = slot_inc; hidx_nxt = '0; st_nxt = S_TICK;
            end
            MODE_QUERY: begin
              idx_nxt = '0; sum_nxt = '0; cdone_nxt = 1'b0; st_nxt = S_QRD;
            end
            MODE_ROLL: begin
              odb_nxt = dayb_r; odp_nxt = dayp_r;
              dayb_nxt = '0; dayp_nxt = '0; st_nxt = S_OUT;
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_FRD: begin
        re = 1'b1; raddr = addr_of(cur_r.host, slot_r); st_nxt = S_FWR;
      end
      S_FWR: begin
        we = 1'b1; waddr = addr_of(cur_r.host, slot_r);
        wdata = slot_sum[COUNT_BITS] ? SLOT_MAX : slot_sum[COUNT_BITS-1:0];
        dayb_nxt = db_sum[DAYB_W] ? DAYB_MAX : db_sum[DAYB_W-1:0];
        dayp_nxt = (dayp_r == DAYP_MAX) ? DAYP_MAX : dayp_r + 1'b1;
        oc_nxt = 1'b1; oh_nxt = 8'(cur_r.host); st_nxt = S_OUT;
      end
      S_TICK: begin
        we = 1'b1; waddr = addr_of(hidx_r, slot_r);
        hidx_nxt = hidx_r + 1'b1;
        if (hidx_r == HOST_W'(HOSTS-1)) st_nxt = S_OUT;
      end
      S_QRD: begin
        // one read per cycle, accumulate the previous one
        if (rdv_r) sum_nxt = win_sum[WIN_W] ? WIN_MAX : win_sum[WIN_W-1:0];
        if (!cdone_r) begin
          re = 1'b1; raddr = addr_of(cur_r.host, idx_r); rdv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == SLOT_LAST) cdone_nxt = 1'b1;
        end else if (!rdv_r) begin
          st_nxt = S_QSUM;
        end
      end
      S_QSUM: begin
        ow_nxt = sum_r; oh_nxt = 8'(cur_r.host); st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; slot_r <= '0; idx_r <= '0; hidx_r <= '0; cdone_r <= 1'b0;
      rdv_r <= 1'b0; dayb_r <= '0; dayp_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; slot_r <= slot_nxt; idx_r <= idx_nxt; hidx_r <= hidx_nxt;
      cdone_r <= cdone_nxt; rdv_r <= rdv_nxt; dayb_r <= dayb_nxt;
      dayp_r <= dayp_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; sum_r <= sum_nxt; oc_r <= oc_nxt; oh_r <= oh_nxt;
    ow_r <= ow_nxt; odb_r <= odb_nxt; odp_r <= odp_nxt;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

endmodule

@@ test/tb_per_host_window_byte_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_host_window_byte_counter
// Drives frame, tick, query and rollover requests into the per-host window
// byte counter under random idling, and checks each result against a typed-in
// expectation or a predictor. The predictor keeps its own slot ring, daily
// totals and subnet registers.
// ----------------------------------------------------------------------------
module tb_per_host_window_byte_counter;
  import phwbc_pkg::*;

  localparam logic [2:0] ADDR_MASK  = 3'd0;
  localparam logic [2:0] ADDR_VALUE = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  mac;
    logic [7:0]  eth;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    logic [7:0]  qh;
  } request_t;

  typedef struct packed {
    logic        counted;
    logic [7:0]  host;
    logic [37:0] win;
    logic [47:0] dayb;
    logic [39:0] dayp;
  } result_t;

  // directed row: request, plus a typed-in result when known at a glance
  typedef struct packed {
    request_t req;
    logic     has_exp;
    result_t  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  phwbc_in_if  in_ch ();
  phwbc_out_if out_ch ();

  per_host_window_byte_counter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [COUNT_BITS-1:0] host_slots [HOSTS][SLOTS];
  int unsigned           slot_now;
  logic [47:0]           day_byte_total;
  logic [39:0]           day_pkt_total;
  logic [31:0]           local_mask, local_value;

  result_t     pending_results [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_sent = 0;
  int          frames_counted = 0;
  bit          no_idle = 1'b0;
  bit          hold_sink = 1'b0;

  function automatic logic [63:0] add_capped(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] cap);
    if (a >= cap || b > cap - a) return cap;
    return a + b;
  endfunction

  function automatic result_t account_request(request_t r);
    result_t     res;
    bit          sl, dl;
    logic [31:0] loc;
    logic [63:0] sum;
    res = '0;
    case (mode_t'(r.mode))
      MODE_FRAME: begin
        sl = (r.src & local_mask) == local_value;
        dl = (r.dst & local_mask) == local_value;
        loc = dl ? r.dst : r.src;
        if (r.mac != MAC_BCAST && r.eth == ETH_IPV4_HI && sl != dl
            && loc[15:8] == 8'h00) begin
          host_slots[loc[7:0]][slot_now] = add_capped(
            host_slots[loc[7:0]][slot_now], r.len, SLOT_MAX);
          day_byte_total = add_capped(day_byte_total, r.len, DAYB_MAX);
          day_pkt_total = add_capped(day_pkt_total, 1, DAYP_MAX);
          res.counted = 1'b1;
          res.host = loc[7:0];
        end
      end
      MODE_TICK: begin
        slot_now = (slot_now + 1) % SLOTS;
        for (int h = 0; h < HOSTS; h++) host_slots[h][slot_now] = '0;
      end
      MODE_QUERY: begin
        sum = 0;
        for (int s = 0; s < SLOTS; s++)
          sum = add_capped(sum, host_slots[r.qh][s], WIN_MAX);
        res.host = r.qh;
        res.win = sum[37:0];
      end
      default: begin
        res.dayb = day_byte_total;
        res.dayp = day_pkt_total;
        day_byte_total = '0;
        day_pkt_total = '0;
      end
    endcase
    return res;
  endfunction

  // register write: setup then access cycle
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_MASK) local_mask = data;
    else local_value = data;
  endtask

  // send one request; a directed expectation overrides the predicted one
  task automatic send_request(request_t r, bit has_exp, result_t exp);
    result_t pred;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.mode, in_ch.dest_mac_first, in_ch.ethertype_high, in_ch.source_address,
     in_ch.dest_address, in_ch.frame_length, in_ch.query_host} <= r;
    do @(posedge clk); while (!in_ch.ready);
    pred = account_request(r);
    if (pred.counted) frames_counted++;
    pending_results.push_back(has_exp ? exp : pred);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOSTS + 8) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int       k;
    r.mac = ($urandom_range(0, 9) == 0) ? MAC_BCAST : 8'($urandom);
    r.eth = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ETH_IPV4_HI;
    r.src = $urandom;
    r.dst = $urandom;
    r.len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
    r.qh = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    // mostly well-formed local frames on a small host set
    k = $urandom_range(0, 3);
    if (k != 0) begin
      logic [31:0] loc;
      loc = (local_value & local_mask) | ($urandom & ~local_mask);
      loc[15:8] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
      if ((loc & local_mask) != local_value) loc = local_value;
      if ($urandom_range(0, 4) != 0) loc[7:0] = 8'($urandom_range(0, 7));
      if (k == 1) r.src = loc; else r.dst = loc;
    end
    k = $urandom_range(0, 99);
    r.mode = (k < 80) ? MODE_FRAME : (k < 86) ? MODE_TICK : (k < 96) ? MODE_QUERY
           : MODE_ROLL;
    return r;
  endfunction

  // result sink with random stalls and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_t got, want;
      got = {out_ch.counted, out_ch.host_index, out_ch.window_bytes,
             out_ch.day_bytes, out_ch.day_packets};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: counted %b/%b host %0d/%0d win %0d/%0d day %0d/%0d pkt %0d/%0d",
                     want.counted, got.counted, want.host, got.host, want.win,
                     got.win, want.dayb, got.dayb, want.dayp, got.dayp);
        end
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  row_t rows [$];

  function automatic row_t mk(logic [1:0] mode, logic [7:0] mac, logic [7:0] eth,
                              logic [31:0] src, logic [31:0] dst, logic [15:0] len,
                              logic [7:0] qh, bit he, result_t e);
    row_t r;
    r.req = {mode, mac, eth, src, dst, len, qh};
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  initial begin
    result_t z;
    z = '0;
    in_ch.valid = 1'b0;
    {in_ch.mode, in_ch.dest_mac_first, in_ch.ethertype_high, in_ch.source_address,
     in_ch.dest_address, in_ch.frame_length, in_ch.query_host} = '0;
    local_mask = MASK_RESET;
    local_value = VALUE_RESET;
    slot_now = 0;
    day_byte_total = '0;
    day_pkt_total = '0;
    for (int h = 0; h < HOSTS; h++)
      for (int s = 0; s < SLOTS; s++) host_slots[h][s] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    rows.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 8'hFF, 1, {1'b0, 8'hFF, 38'd0, 48'd0, 40'd0}));
    rows.push_back(mk(MODE_ROLL, 0, 0, 0, 0, 0, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h00, 8'h08, 32'hC0A8_0005, 32'h0A00_0001, 16'hFFFF, 0,
                      1, {1'b1, 8'd5, 38'd0, 48'd0, 40'd0}));
    rows.push_back(mk(MODE_FRAME, 8'hFE, 8'h08, 32'h0A00_0001, 32'hC0A8_00FF, 16'h0000, 0,
                      1, {1'b1, 8'hFF, 38'd0, 48'd0, 40'd0}));
    // broadcast, wrong ethertype, both local, neither local, nonzero bits 15..8
    rows.push_back(mk(MODE_FRAME, 8'hFF, 8'h08, 32'hC0A8_0001, 32'h0A00_0001, 100, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h01, 8'h86, 32'hC0A8_0001, 32'h0A00_0001, 100, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h01, 8'h08, 32'hC0A8_0001, 32'hC0A8_0002, 100, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h01, 8'h08, 32'h0A00_0001, 32'h0B00_0002, 100, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h01, 8'h08, 32'hC0A8_FF01, 32'h0A00_0001, 100, 0, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h01, 8'h08, 32'hFFFF_FFFF, 32'hC0A8_0005, 1000, 0, 0, z));
    rows.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 8'd5, 0, z));
    rows.push_back(mk(MODE_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                      8'hFF, 1, z));
    rows.push_back(mk(MODE_FRAME, 8'h00, 8'h08, 32'h0000_0000, 32'hC0A8_0005, 7, 0, 0, z));
    rows.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 8'd5, 0, z));
    rows.push_back(mk(MODE_QUERY, 0, 0, 0, 0, 0, 8'd0, 0, z));
    rows.push_back(mk(MODE_ROLL, 0, 0, 0, 0, 0, 0, 0, z));
    rows.push_back(mk(MODE_ROLL, 0, 0, 0, 0, 0, 0, 1, z));
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
    drain_results();

    // random phases over several subnet settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin write_reg(ADDR_MASK, 32'h0000_0000); write_reg(ADDR_VALUE, 32'h0000_0000); end
        2: begin write_reg(ADDR_MASK, 32'hFFFF_FFFF); write_reg(ADDR_VALUE, 32'hFFFF_0000); end
        3: begin write_reg(ADDR_MASK, 32'hFF00_0000); write_reg(ADDR_VALUE, 32'h0A00_0000); end
        4: begin write_reg(ADDR_MASK, MASK_RESET); write_reg(ADDR_VALUE, VALUE_RESET); end
        default: ;
      endcase
      if (ph == 2) hold_sink = 1'b1;
      if (ph == 4) no_idle = 1'b1;
      for (int n = 0; n < 200; n++) send_request(random_request(), 0, z);
      drain_results();
    end

    $display("covered %0d requests, %0d results, %0d frames credited, 5 subnet settings",
             requests_sent, results_seen, frames_counted);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
